/* rtl/pft_pkg.sv */
// shared types and constants of the predictive fridge thermostat
package pft_pkg;

    // fixed temperature limits, Q8.8, and tuning constants
    localparam logic signed [15:0] COOL_TEMP_LIMIT = 16'sd7680;
    localparam logic signed [15:0] HEAT_TEMP_LIMIT = 16'sd0;
    localparam logic [6:0]  PEAK_TOLERANCE  = 7'd64;
    localparam logic [15:0] EST_RESET       = 16'd7680;
    localparam logic [15:0] EST_MIN         = 16'd13;
    localparam logic [14:0] DUTY_MIN        = 15'd512;
    localparam logic [15:0] F_BASE          = 16'd30720;
    localparam logic [15:0] F_MAX           = 16'd38400;
    localparam logic [15:0] F_UNIT          = 16'd25600;

    // reciprocals for exact 32-bit division by constants
    // x / 1000 = (x * RCP_1000) >> 38, x / 3600 = (x * RCP_3600) >> 43,
    // x / 25600 = (x * RCP_25600) >> 46
    localparam logic [31:0] RCP_1000        = 32'd274877907;
    localparam logic [31:0] RCP_3600        = 32'd2443359173;
    localparam logic [31:0] RCP_25600       = 32'd2748779070;

    // configuration register indexes
    localparam logic [3:0] CFG_IDLE_BAND   = 4'd0;
    localparam logic [3:0] CFG_COOL_MIN_ON = 4'd1;
    localparam logic [3:0] CFG_COOL_MIN_OFF = 4'd2;
    localparam logic [3:0] CFG_HEAT_MIN_OFF = 4'd3;
    localparam logic [3:0] CFG_COOL_MAX_ON = 4'd4;
    localparam logic [3:0] CFG_PEAK_MAX_TIME = 4'd5;
    localparam logic [3:0] CFG_PEAK_MAX_WAIT = 4'd6;
    localparam logic [3:0] CFG_HEAT_WINDOW = 4'd7;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_COOL = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIV_RUN, OP_SET_RUNS, OP_DIV_OFF, OP_SET_OFFS,
        OP_REQ, OP_COOL_STOP, OP_MUL_PRED, OP_DIV_PRED, OP_COOL_PRED,
        OP_DIV_WIN, OP_HEAT_WRAP, OP_MUL_RUN, OP_MUL_WIN, OP_HEAT_FIN,
        OP_IDLE_START, OP_TUNE_SKIP, OP_MUL_TUNE, OP_DIV_TUNE, OP_TUNE_FIN,
        OP_OUT_LOAD
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_RUN_GO, S_RUN_WAIT, S_OFF_GO, S_OFF_WAIT, S_DECIDE,
        S_PMUL, S_PDIV_GO, S_PDIV_WAIT, S_WDIV_GO, S_WDIV_WAIT,
        S_HMUL1, S_HMUL2, S_HFIN, S_TMUL, S_TDIV_GO, S_TDIV_WAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic        div_busy;
        logic        req;
        t_mode       mode;
        t_mode       prior;
        logic        cool_go;
        logic        temp_lt_lo;
        logic        heat_wrap;
        logic        tune_go;
        logic        tune_skip;
    } t_dp_status;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        now_ms;
        logic signed [15:0] filtered_temp;
        logic signed [15:0] target_temp;
        logic [14:0]        heat_duty;
        logic               peak_seen;
    } t_item;

    typedef struct packed {
        logic        compressor_on;
        logic        heater_on;
        logic        lamp_on;
        logic [1:0]  mode_now;
        logic        awaiting_peak;
        logic [15:0] overshoot_rate;
        logic        idle_refused;
        logic        clear_heat_integral;
        logic        save_estimator;
    } t_result;

endpackage

/* rtl/pft_ifs.sv */
// channel interfaces: tick input, result output, configuration write
interface pft_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [31:0]        now_ms;
    logic signed [15:0] filtered_temp;
    logic signed [15:0] target_temp;
    logic [14:0]        heat_duty;
    logic               peak_seen;
    modport source (output valid, req_type, now_ms, filtered_temp, target_temp,
                    heat_duty, peak_seen, input ready);
    modport sink (input valid, req_type, now_ms, filtered_temp, target_temp,
                  heat_duty, peak_seen, output ready);
endinterface

interface pft_out_if;
    logic        valid;
    logic        ready;
    logic        compressor_on;
    logic        heater_on;
    logic        lamp_on;
    logic [1:0]  mode_now;
    logic        awaiting_peak;
    logic [15:0] overshoot_rate;
    logic        idle_refused;
    logic        clear_heat_integral;
    logic        save_estimator;
    modport source (output valid, compressor_on, heater_on, lamp_on, mode_now,
                    awaiting_peak, overshoot_rate, idle_refused,
                    clear_heat_integral, save_estimator, input ready);
    modport sink (input valid, compressor_on, heater_on, lamp_on, mode_now,
                  awaiting_peak, overshoot_rate, idle_refused,
                  clear_heat_integral, save_estimator, output ready);
endinterface

interface pft_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pft_div.sv */
// restoring divider, one quotient bit per cycle
module pft_div
    import pft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [32:0] o_quot,
    output logic [31:0] o_rem
);
    logic [32:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] trial;
    logic        fit;

    assign trial = {r_rem, r_q[32]};
    assign fit   = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd33;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_busy <= r_cnt != 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fit ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_q   <= {r_q[31:0], fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

/* rtl/pft_dp.sv */
// thermostat datapath: state, configuration, shared multiplier and divider
module pft_dp
    import pft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_dp_status  o_stat,
    output t_result     o_res
);
    // configuration
    logic [11:0] r_band;
    logic [15:0] r_min_on, r_cool_off, r_heat_off, r_max_on, r_pk_time, r_pk_wait;
    logic [31:0] r_window;
    // item
    t_item r_it;
    // state
    t_mode              r_mode, r_prior;
    logic [31:0]        r_run_start, r_idle_start;
    logic               r_ever;
    logic [15:0]        r_est;
    logic signed [15:0] r_pred;
    logic               r_comp, r_heat;
    logic               r_refused, r_clr, r_save;
    // work
    logic [22:0] r_run_s, r_off_s;
    logic [31:0] r_run_h;
    logic [47:0] r_prod, r_prod2;
    logic [32:0] r_cq;
    logic        r_use_c;
    t_result     r_res;

    logic signed [17:0] hi, lo, temp18;
    logic [31:0] win, run_now, off_now;
    logic [14:0] duty;
    logic [15:0] t_cap;
    logic signed [16:0] err;
    logic [16:0] mag;
    logic [18:0] f_raw;
    logic [15:0] f;
    logic        err_pos;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic [31:0] rcp_a;
    logic [31:0] rcp_m;
    logic [63:0] rcp_p;
    logic [32:0] rcp_q;
    logic        div_start;
    logic [32:0] div_num;
    logic [31:0] div_den;
    logic        div_busy;
    logic [32:0] quot;
    logic [31:0] rem;
    logic [32:0] q;
    logic signed [33:0] pred;
    logic [31:0] run_wrap;

    assign temp18  = 18'(r_it.filtered_temp);
    assign hi      = 18'(r_it.target_temp) + $signed({6'd0, r_band});
    assign lo      = 18'(r_it.target_temp) - $signed({6'd0, r_band});
    assign win     = (r_window == '0) ? 32'd1 : r_window;
    assign run_now = r_it.now_ms - r_run_start;
    assign off_now = r_it.now_ms - r_idle_start;
    assign duty    = (r_it.heat_duty < DUTY_MIN) ? '0 : r_it.heat_duty;
    assign t_cap   = (r_run_s < {7'd0, r_pk_time}) ? r_run_s[15:0] : r_pk_time;

    // estimator error and correction factor
    assign err     = 17'(r_pred) - 17'(r_it.filtered_temp);
    assign err_pos = err > 17'sd0;
    assign mag     = err[16] ? 17'(-err) : 17'(err);
    assign f_raw   = 19'(mag) * 19'd3 + 19'(F_BASE);
    assign f       = (f_raw > 19'(F_MAX)) ? F_MAX : f_raw[15:0];
    assign run_wrap = rem + 32'd1;

    // quotient of the last division, by constant or through the divider
    assign q    = r_use_c ? r_cq : quot;
    assign pred = 34'(r_it.filtered_temp) - $signed({1'b0, q});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_MUL_PRED: begin
                mul_a = {16'd0, t_cap};
                mul_b = r_est;
            end
            OP_MUL_TUNE: begin
                mul_a = {16'd0, r_est};
                mul_b = err_pos ? f : F_UNIT;
            end
            OP_MUL_RUN: begin
                mul_a = r_run_h;
                mul_b = F_UNIT;
            end
            OP_MUL_WIN: begin
                mul_a = win;
                mul_b = {1'b0, duty};
            end
            default: ;
        endcase
    end
    assign mul_p = 48'(mul_a) * 48'(mul_b);

    // division by a constant: one reciprocal multiply, quotient registered
    always_comb begin
        rcp_a = '0;
        rcp_m = '0;
        case (i_op)
            OP_DIV_RUN: begin
                rcp_a = run_now;
                rcp_m = RCP_1000;
            end
            OP_DIV_OFF: begin
                rcp_a = off_now;
                rcp_m = RCP_1000;
            end
            OP_DIV_PRED: begin
                rcp_a = r_prod[31:0] + 32'd1800;
                rcp_m = RCP_3600;
            end
            OP_DIV_TUNE: begin
                rcp_a = r_prod[31:0] + 32'd12800;
                rcp_m = RCP_25600;
            end
            default: ;
        endcase
    end
    assign rcp_p = {32'd0, rcp_a} * {32'd0, rcp_m};

    always_comb begin
        case (i_op)
            OP_DIV_PRED: rcp_q = {12'd0, rcp_p[63:43]};
            OP_DIV_TUNE: rcp_q = {15'd0, rcp_p[63:46]};
            default:     rcp_q = {7'd0, rcp_p[63:38]};
        endcase
    end

    // divider only for the window and the downward retune
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 32'd1;
        case (i_op)
            OP_DIV_WIN: begin
                div_start = 1'b1;
                div_num   = {1'b0, r_run_h - 32'd1};
                div_den   = win;
            end
            OP_DIV_TUNE: begin
                if (!err_pos) begin
                    div_start = 1'b1;
                    div_num   = r_prod[32:0] + 33'(f[15:1]);
                    div_den   = {16'd0, f};
                end
            end
            default: ;
        endcase
    end

    pft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band     <= 12'd128;
            r_min_on   <= 16'd180;
            r_cool_off <= 16'd300;
            r_heat_off <= 16'd300;
            r_max_on   <= 16'd7200;
            r_pk_time  <= 16'd1200;
            r_pk_wait  <= 16'd1800;
            r_window   <= 32'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDLE_BAND:     r_band     <= i_cfg_data[11:0];
                CFG_COOL_MIN_ON:   r_min_on   <= i_cfg_data[15:0];
                CFG_COOL_MIN_OFF:  r_cool_off <= i_cfg_data[15:0];
                CFG_HEAT_MIN_OFF:  r_heat_off <= i_cfg_data[15:0];
                CFG_COOL_MAX_ON:   r_max_on   <= i_cfg_data[15:0];
                CFG_PEAK_MAX_TIME: r_pk_time  <= i_cfg_data[15:0];
                CFG_PEAK_MAX_WAIT: r_pk_wait  <= i_cfg_data[15:0];
                CFG_HEAT_WINDOW:   r_window   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_prior      <= MODE_IDLE;
            r_run_start  <= '0;
            r_idle_start <= '0;
            r_ever       <= 1'b0;
            r_est        <= EST_RESET;
            r_pred       <= '0;
            r_comp       <= 1'b0;
            r_heat       <= 1'b0;
            r_refused    <= 1'b0;
            r_clr        <= 1'b0;
            r_save       <= 1'b0;
        end else begin
            case (i_op)
                OP_LOAD: begin
                    r_refused <= 1'b0;
                    r_clr     <= 1'b0;
                    r_save    <= 1'b0;
                end
                OP_REQ: begin
                    if (r_mode == MODE_COOL && r_run_s < {7'd0, r_min_on}) begin
                        r_refused <= 1'b1;
                    end else begin
                        r_comp  <= 1'b0;
                        r_heat  <= 1'b0;
                        r_mode  <= MODE_IDLE;
                        r_prior <= MODE_IDLE;
                    end
                end
                OP_COOL_STOP: begin
                    r_comp       <= 1'b0;
                    r_heat       <= 1'b0;
                    r_mode       <= MODE_IDLE;
                    r_prior      <= MODE_IDLE;
                    r_idle_start <= r_it.now_ms;
                    r_ever       <= 1'b1;
                end
                OP_COOL_PRED: begin
                    if (pred < 34'(lo)) begin
                        r_pred <= (pred < -34'sd32768) ? 16'h8000 : pred[15:0];
                    end
                    // the maximum run time wins over the predicted stop
                    if (r_run_s > {7'd0, r_max_on}) begin
                        r_comp       <= 1'b0;
                        r_mode       <= MODE_IDLE;
                        r_prior      <= MODE_IDLE;
                        r_idle_start <= r_it.now_ms;
                        r_ever       <= 1'b1;
                    end else if (pred < 34'(lo)) begin
                        r_comp       <= 1'b0;
                        r_prior      <= MODE_COOL;
                        r_mode       <= MODE_IDLE;
                        r_idle_start <= r_it.now_ms;
                        r_ever       <= 1'b1;
                    end
                end
                OP_HEAT_WRAP: begin
                    r_run_start <= r_it.now_ms - run_wrap;
                end
                OP_HEAT_FIN: begin
                    if (temp18 > hi) begin
                        r_comp       <= 1'b0;
                        r_heat       <= 1'b0;
                        r_mode       <= MODE_IDLE;
                        r_prior      <= MODE_IDLE;
                        r_idle_start <= r_it.now_ms;
                        r_ever       <= 1'b1;
                    end else begin
                        r_heat <= r_prod2 < r_prod;
                    end
                end
                OP_IDLE_START: begin
                    if (temp18 > hi && (r_off_s > {7'd0, r_cool_off} || !r_ever)
                            && r_it.filtered_temp < COOL_TEMP_LIMIT) begin
                        r_mode      <= MODE_COOL;
                        r_comp      <= 1'b1;
                        r_run_start <= r_it.now_ms;
                    end else if (temp18 < lo
                            && (r_off_s > {7'd0, r_heat_off} || !r_ever)
                            && r_it.filtered_temp > HEAT_TEMP_LIMIT) begin
                        r_mode      <= MODE_HEAT;
                        r_clr       <= 1'b1;
                        r_run_start <= r_it.now_ms;
                    end
                end
                OP_TUNE_SKIP: begin
                    r_prior <= MODE_IDLE;
                end
                OP_TUNE_FIN: begin
                    r_prior <= MODE_IDLE;
                    r_save  <= 1'b1;
                    if (err_pos) begin
                        r_est <= (q > 33'd65535) ? 16'hFFFF : q[15:0];
                    end else begin
                        r_est <= (q < {17'd0, EST_MIN}) ? EST_MIN : q[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers and result
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD:      r_it <= i_item;
            OP_DIV_RUN, OP_DIV_OFF, OP_DIV_PRED: begin
                r_cq    <= rcp_q;
                r_use_c <= 1'b1;
            end
            OP_DIV_TUNE: begin
                r_cq    <= rcp_q;
                r_use_c <= err_pos;
            end
            OP_DIV_WIN:   r_use_c <= 1'b0;
            OP_SET_RUNS: begin
                r_run_s <= q[22:0];
                r_run_h <= run_now;
            end
            OP_SET_OFFS:  r_off_s <= q[22:0];
            OP_HEAT_WRAP: r_run_h <= run_wrap;
            OP_MUL_PRED, OP_MUL_TUNE, OP_MUL_RUN, OP_MUL_WIN: begin
                r_prod  <= mul_p;
                r_prod2 <= r_prod;
            end
            OP_OUT_LOAD: begin
                r_res.compressor_on       <= r_comp;
                r_res.heater_on           <= r_heat;
                r_res.lamp_on             <= r_comp;
                r_res.mode_now            <= r_mode;
                r_res.awaiting_peak       <= r_mode != MODE_HEAT && r_mode != MODE_COOL
                                             && r_prior == MODE_COOL;
                r_res.overshoot_rate      <= r_est;
                r_res.idle_refused        <= r_refused;
                r_res.clear_heat_integral <= r_clr;
                r_res.save_estimator      <= r_save;
            end
            default: ;
        endcase
    end

    assign o_stat.div_busy   = div_busy;
    assign o_stat.req        = r_it.req_type;
    assign o_stat.mode       = r_mode;
    assign o_stat.prior      = r_prior;
    assign o_stat.cool_go    = r_run_s >= {7'd0, r_min_on};
    assign o_stat.temp_lt_lo = temp18 < lo;
    assign o_stat.heat_wrap  = r_run_h > win;
    assign o_stat.tune_go    = r_it.peak_seen || r_off_s >= {7'd0, r_pk_wait};
    assign o_stat.tune_skip  = err <= 17'sd0 && err >= -$signed({10'd0, PEAK_TOLERANCE});
    assign o_res = r_res;
endmodule

/* rtl/pft_ctrl.sv */
// thermostat sequencer: steps the datapath through one word
module pft_ctrl
    import pft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_op        o_op
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_RUN_GO;
                end
            end
            S_RUN_GO: begin
                o_op    = OP_DIV_RUN;
                n_state = S_RUN_WAIT;
            end
            S_RUN_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_op    = OP_SET_RUNS;
                    n_state = S_OFF_GO;
                end
            end
            S_OFF_GO: begin
                o_op    = OP_DIV_OFF;
                n_state = S_OFF_WAIT;
            end
            S_OFF_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_op    = OP_SET_OFFS;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                if (i_stat.req) begin
                    o_op = OP_REQ;
                end else if (i_stat.mode == MODE_COOL) begin
                    if (i_stat.cool_go) begin
                        if (i_stat.temp_lt_lo) o_op = OP_COOL_STOP;
                        else n_state = S_PMUL;
                    end
                end else if (i_stat.mode == MODE_HEAT) begin
                    n_state = i_stat.heat_wrap ? S_WDIV_GO : S_HMUL1;
                end else if (i_stat.prior == MODE_IDLE) begin
                    o_op = OP_IDLE_START;
                end else if (i_stat.prior == MODE_COOL && i_stat.tune_go) begin
                    if (i_stat.tune_skip) o_op = OP_TUNE_SKIP;
                    else n_state = S_TMUL;
                end
            end
            S_PMUL: begin
                o_op    = OP_MUL_PRED;
                n_state = S_PDIV_GO;
            end
            S_PDIV_GO: begin
                o_op    = OP_DIV_PRED;
                n_state = S_PDIV_WAIT;
            end
            S_PDIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_op    = OP_COOL_PRED;
                    n_state = S_OUT;
                end
            end
            S_WDIV_GO: begin
                o_op    = OP_DIV_WIN;
                n_state = S_WDIV_WAIT;
            end
            S_WDIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_op    = OP_HEAT_WRAP;
                    n_state = S_HMUL1;
                end
            end
            S_HMUL1: begin
                o_op    = OP_MUL_RUN;
                n_state = S_HMUL2;
            end
            S_HMUL2: begin
                o_op    = OP_MUL_WIN;
                n_state = S_HFIN;
            end
            S_HFIN: begin
                o_op    = OP_HEAT_FIN;
                n_state = S_OUT;
            end
            S_TMUL: begin
                o_op    = OP_MUL_TUNE;
                n_state = S_TDIV_GO;
            end
            S_TDIV_GO: begin
                o_op    = OP_DIV_TUNE;
                n_state = S_TDIV_WAIT;
            end
            S_TDIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_op    = OP_TUNE_FIN;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op        = OP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

/* rtl/predictive_fridge_thermostat.sv */
// top level of the predictive fridge thermostat
//
// channel   dir  handshake      payload
// i_item    in   valid/ready    req_type now_ms filtered_temp target_temp heat_duty peak_seen
// o_result  out  valid/ready    relays, lamp, mode, peak wait, estimator, pulses
// i_cfg     in   valid/ready    index (register number), data
//
// a plain word steps through load, run and idle division, decision and result
// load; run and idle seconds come from reciprocal multiplies; a cooling
// prediction, a heating update or an upward retune adds its multiply steps, a
// downward retune and a heater window wrap use the 33-step restoring divider
// reset is synchronous, active low; it loads the default settings and idles
// a new word is taken while the previous result still waits in the output
// register; a stalled output holds the sequencer before its result load
module predictive_fridge_thermostat
    import pft_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pft_in_if.sink        i_item,
    pft_out_if.source     o_result,
    pft_cfg_if.sink       i_cfg
);
    t_item      item;
    t_op        op;
    t_dp_status stat;
    t_result    res;
    logic       in_ready;
    logic       out_valid;

    // pack the incoming word
    assign item.req_type      = i_item.req_type;
    assign item.now_ms        = i_item.now_ms;
    assign item.filtered_temp = i_item.filtered_temp;
    assign item.target_temp   = i_item.target_temp;
    assign item.heat_duty     = i_item.heat_duty;
    assign item.peak_seen     = i_item.peak_seen;
    assign i_item.ready       = in_ready;

    // settings are always writable
    assign i_cfg.ready = 1'b1;

    pft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_op        (op)
    );

    pft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_stat      (stat),
        .o_res       (res)
    );

    // result word
    assign o_result.valid               = out_valid;
    assign o_result.compressor_on       = res.compressor_on;
    assign o_result.heater_on           = res.heater_on;
    assign o_result.lamp_on             = res.lamp_on;
    assign o_result.mode_now            = res.mode_now;
    assign o_result.awaiting_peak       = res.awaiting_peak;
    assign o_result.overshoot_rate      = res.overshoot_rate;
    assign o_result.idle_refused        = res.idle_refused;
    assign o_result.clear_heat_integral = res.clear_heat_integral;
    assign o_result.save_estimator      = res.save_estimator;
endmodule
